### rtl/core/mse_pkg.sv
// Shared types, command and status codes for the max stack engine.
`default_nettype none

package mse_pkg;

    localparam int DATA_W              = 32;
    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int CMD_W               = 3;
    localparam int STATUS_W            = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TOP      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK_MAX = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_MAX  = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SCAN_END,
        S_SHIFT,
        S_DONE
    } state_t;

    // control from the sequencer to the max scan unit
    typedef struct packed {
        logic valid;   // a stored word is on the read port this cycle
        logic first;   // it is the topmost word of the scan
    } scan_ctl_t;

endpackage

`default_nettype wire

### rtl/core/mse_max_scan.sv
// Running maximum over words read top-down from the stack memory.
`default_nettype none

module mse_max_scan #(
    parameter int IDX_W = 6
) (
    input  wire logic                        clk,
    input  wire mse_pkg::scan_ctl_t          ctl,
    input  wire logic signed [mse_pkg::DATA_W-1:0] value,
    input  wire logic [IDX_W-1:0]            idx,
    output logic signed [mse_pkg::DATA_W-1:0] best_value,
    output logic [IDX_W-1:0]                 best_idx
);
    import mse_pkg::*;

    logic signed [DATA_W-1:0] best_value_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic                     take;

    // strict compare: on a tie the higher (earlier seen) entry is kept
    assign take = ctl.valid && (ctl.first || (value > best_value_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_value_reg <= value;
            best_idx_reg   <= idx;
        end
    end

    assign best_value = best_value_reg;
    assign best_idx   = best_idx_reg;

endmodule

`default_nettype wire

### rtl/core/max_stack_engine.sv
// Top level of the max stack engine: sequencer, stack memory and output register.
//
// Usage:
//   Commands enter on the s_axis channel: s_axis_tuser carries the command
//   (push, pop, top, peek max, pop max), s_axis_tdata the value to push.
//   Every word accepted gives exactly one result word on m_axis: tdata holds
//   the value, tuser the status (ok, empty, full).
//   States from acceptance to the result being offered:
//     push, invalid command, or any command on an empty stack: IDLE, DONE
//     pop, top: IDLE, READ, DONE
//     peek max: IDLE, SCAN, SCAN_END, DONE
//     pop max: as peek max, with SHIFT before DONE when the maximum is not on top
//   These paths follow from the single read port of the stack memory
//   (one word per cycle, registered read): the maximum search reads every
//   entry, and closing the gap after pop max moves one entry per cycle. One
//   command is worked on at a time; the next is accepted as soon as the
//   result sits in the output register.
//   Reset clears the entry count and the control state; memory contents are
//   left as they are and never read before a push writes them.
//   When the receiver stalls, the result waits in the output register; a
//   following command may run but holds its result until that slot frees.
`default_nettype none

module max_stack_engine #(
    parameter int STACK_DEPTH = mse_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [mse_pkg::DATA_W-1:0]    s_axis_tdata,   // [31:0] push_value
    input  wire logic [mse_pkg::CMD_W-1:0]     s_axis_tuser,   // [2:0] command
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [mse_pkg::DATA_W-1:0]         m_axis_tdata,   // [31:0] result_value
    output logic [mse_pkg::STATUS_W-1:0]       m_axis_tuser    // [1:0] status
);
    import mse_pkg::*;

    localparam int IW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // stack memory, one write and one registered read port
    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              mem_wr_en;
    logic [IW-1:0]     mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [IW-1:0]     mem_rd_addr;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     data_idx_reg, data_idx_next;   // index of word on rd_data_reg
    logic              first_reg, first_next;
    logic [IW-1:0]     sh_idx_reg, sh_idx_next;       // destination of gap closing
    logic              popmax_reg, popmax_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_value_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_load;

    scan_ctl_t                 scan_ctl;
    logic signed [DATA_W-1:0]  best_value;
    logic [IW-1:0]             best_idx;
    logic [IW-1:0]             top_idx;

    assign top_idx = IW'(count_reg - CW'(1));

    mse_max_scan #(
        .IDX_W (IW)
    ) u_scan (
        .clk        (clk),
        .ctl        (scan_ctl),
        .value      (signed'(rd_data_reg)),
        .idx        (data_idx_reg),
        .best_value (best_value),
        .best_idx   (best_idx)
    );

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_idx_reg   <= data_idx_next;
        first_reg      <= first_next;
        sh_idx_reg     <= sh_idx_next;
        popmax_reg     <= popmax_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        data_idx_next   = data_idx_reg;
        first_next      = first_reg;
        sh_idx_next     = sh_idx_reg;
        popmax_next     = popmax_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = sh_idx_reg;
        mem_wr_data     = rd_data_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = top_idx;
        scan_ctl        = '0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    res_value_next  = '0;
                    res_status_next = STAT_OK;
                    state_next      = S_DONE;
                    if (s_axis_tuser == CMD_PUSH)
                    begin
                        if (count_reg == CW'(STACK_DEPTH))
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = count_reg[IW-1:0];
                            mem_wr_data = s_axis_tdata;
                            count_next  = count_reg + CW'(1);
                        end
                    end
                    else if (s_axis_tuser == CMD_POP || s_axis_tuser == CMD_TOP
                             || s_axis_tuser == CMD_PEEK_MAX
                             || s_axis_tuser == CMD_POP_MAX)
                    begin
                        if (count_reg == '0)
                        begin
                            res_value_next  = EMPTY_VALUE;
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            mem_rd_en     = 1'b1;
                            data_idx_next = top_idx;
                            first_next    = 1'b1;
                            popmax_next   = (s_axis_tuser == CMD_POP_MAX);
                            if (s_axis_tuser == CMD_POP || s_axis_tuser == CMD_TOP)
                            begin
                                state_next = S_READ;
                                if (s_axis_tuser == CMD_POP)
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    end
                end
            end

            S_READ:
            begin
                res_value_next  = rd_data_reg;
                res_status_next = STAT_OK;
                state_next      = S_DONE;
            end

            S_SCAN:
            begin
                scan_ctl.valid = 1'b1;
                scan_ctl.first = first_reg;
                first_next     = 1'b0;
                if (data_idx_reg != '0)
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = data_idx_reg - IW'(1);
                    data_idx_next = data_idx_reg - IW'(1);
                end
                else
                begin
                    state_next = S_SCAN_END;
                end
            end

            S_SCAN_END:
            begin
                res_value_next  = best_value;
                res_status_next = STAT_OK;
                state_next      = S_DONE;
                if (popmax_reg)
                begin
                    if ((CW'(best_idx) + CW'(1)) < count_reg)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = IW'(CW'(best_idx) + CW'(1));
                        sh_idx_next = best_idx;
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end

            S_SHIFT:
            begin
                // rd_data_reg holds the entry just above sh_idx_reg
                mem_wr_en = 1'b1;
                if ((CW'(sh_idx_reg) + CW'(2)) < count_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = IW'(CW'(sh_idx_reg) + CW'(2));
                    sh_idx_next = sh_idx_reg + IW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register: parts the result from the next command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("entry count above stack depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1) || count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CW'(data_idx_reg) < count_reg))
        else $error("scan index outside held entries");

    a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> ((CW'(sh_idx_reg) + CW'(1)) < count_reg))
        else $error("gap closing beyond the top entry");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("result overwrites a word not yet taken");

endmodule

`default_nettype wire

### tb/tb_max_stack_engine.sv
// Self-checking testbench for the max stack engine: directed and random command streams.

module tb_max_stack_engine;

    import mse_pkg::*;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int DEPTH        = DEFAULT_STACK_DEPTH;
    localparam int RANDOM_WORDS = 1500;         // random commands after the directed part
    localparam int TAIL_WORDS   = 150;          // closing stretch run without any idling
    localparam int HOLD_AT      = 400;          // commands taken before the long sink stall
    localparam int HOLD_CYCLES  = 600;          // length of that stall
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;   // worst pop max plus slack
    localparam int CYCLE_LIMIT  = 1_000_000;

    // command codes the block does not define; they must still give a reply
    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;

    localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [DATA_W-1:0] operand;
    } stack_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] status;
    } stack_reply_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata;
    logic [CMD_W-1:0]    s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [DATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    max_stack_engine #(
        .STACK_DEPTH (DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [31:0] push_value
        .s_axis_tuser  (s_axis_tuser),    // [2:0] command
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [31:0] result_value
        .m_axis_tuser  (m_axis_tuser)     // [1:0] status
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    stack_cmd_t   cmd_backlog[$];     // words waiting to be offered
    stack_reply_t replies_due[$];     // predicted replies, oldest first

    int unsigned stim_total    = 0;
    int unsigned words_offered = 0;
    int unsigned words_taken   = 0;
    int unsigned replies_seen  = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned gen_depth     = 0;   // stack depth as the generator tracks it

    int unsigned send_gap  = 0;
    int unsigned sink_gap  = 0;
    int unsigned hold_left = 0;
    bit          hold_started = 1'b0;
    stack_cmd_t  next_cmd;

    // predictor's own copy of the stack
    logic [DATA_W-1:0] stack_words [DEPTH];
    int                stack_fill = 0;

    // ------------------------------------------------------------------
    // Predictor: applies one command to the shadow stack, returns the reply
    // ------------------------------------------------------------------
    function automatic stack_reply_t apply_command(stack_cmd_t c);
        stack_reply_t r;
        int           best;
        int           i;
        r.value  = '0;
        r.status = STAT_OK;
        case (c.op)
            CMD_PUSH:
            begin
                if (stack_fill >= DEPTH)
                    r.status = STAT_FULL;       // dropped, stack untouched
                else
                begin
                    stack_words[stack_fill] = c.operand;
                    stack_fill++;
                end
            end
            CMD_POP, CMD_TOP, CMD_PEEK_MAX, CMD_POP_MAX:
            begin
                if (stack_fill == 0)
                begin
                    r.value  = EMPTY_VALUE;
                    r.status = STAT_EMPTY;
                end
                else if (c.op == CMD_POP)
                begin
                    stack_fill--;
                    r.value = stack_words[stack_fill];
                end
                else if (c.op == CMD_TOP)
                    r.value = stack_words[stack_fill - 1];
                else
                begin
                    // scan downwards; only a strictly larger word moves the pick,
                    // so ties resolve to the topmost occurrence
                    best = stack_fill - 1;
                    for (i = stack_fill - 2; i >= 0; i--)
                        if ($signed(stack_words[i]) > $signed(stack_words[best]))
                            best = i;
                    r.value = stack_words[best];
                    if (c.op == CMD_POP_MAX)
                    begin
                        for (i = best; i < stack_fill - 1; i++)
                            stack_words[i] = stack_words[i + 1];
                        stack_fill--;
                    end
                end
            end
            default: ;  // reserved codes: value 0, status ok, no change
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] operand);
        stack_cmd_t c;
        c.op      = op;
        c.operand = operand;
        cmd_backlog = {cmd_backlog, c};
        if (op == CMD_PUSH && gen_depth < DEPTH)
            gen_depth++;
        else if ((op == CMD_POP || op == CMD_POP_MAX) && gen_depth > 0)
            gen_depth--;
    endtask

    // half full-range words, the rest a narrow pool so ties are common, or extremes
    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
        begin
            case ($urandom_range(0, 4))
                0:       return MOST_NEG;
                1:       return MOST_POS;
                2:       return '0;
                3:       return '1;
                default: return 32'd1;
            endcase
        end
        else if (r < 4)
            return DATA_W'($signed($urandom_range(0, 7)) - 4);
        return $urandom();
    endfunction

    function automatic logic [CMD_W-1:0] pick_reserved();
        case ($urandom_range(0, 2))
            0:       return CMD_RSVD_A;
            1:       return CMD_RSVD_B;
            default: return CMD_RSVD_C;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_reader();
        case ($urandom_range(0, 3))
            0:       return CMD_POP;
            1:       return CMD_TOP;
            2:       return CMD_PEEK_MAX;
            default: return CMD_POP_MAX;
        endcase
    endfunction

    // idling only outside the calm stretches and never in the tail
    function automatic bit idling_allowed(int unsigned progress);
        if (progress + TAIL_WORDS >= stim_total)
            return 1'b0;
        return ((progress / 250) % 4) != 3;
    endfunction

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        $display("MISMATCH reply %0d %s: got %h want %h", replies_seen, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples both handshakes at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                next_cmd.op      = s_axis_tuser;
                next_cmd.operand = s_axis_tdata;
                replies_due = {replies_due, apply_command(next_cmd)};
                words_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (replies_due.size() == 0)
                    flag_mismatch("unexpected word", m_axis_tdata, '0);
                else
                begin
                    stack_reply_t want;
                    want = replies_due.pop_front();
                    if (m_axis_tdata !== want.value)
                        flag_mismatch("result_value", m_axis_tdata, want.value);
                    if (m_axis_tuser !== want.status)
                        flag_mismatch("status", DATA_W'(m_axis_tuser), DATA_W'(want.status));
                end
                replies_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Command driver: presents the next backlog word at the falling edge once
    // the previous one has gone, with random gaps between words
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && words_taken == words_offered)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_backlog.size() > 0)
            begin
                stack_cmd_t c;
                c = cmd_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= c.op;
                s_axis_tdata  <= c.operand;
                words_offered++;
                if (idling_allowed(words_offered) && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 7);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Reply sink: random stall bursts, plus one long hold-off while the
    // driver keeps offering, so the output register and the engine both fill
    // and the input side has to stall
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!hold_started && words_taken >= HOLD_AT)
        begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (idling_allowed(replies_seen) && $urandom_range(0, 7) == 0)
                sink_gap = $urandom_range(1, 7);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("max_stack_engine regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus build, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned kind;
        int unsigned run_len;
        int unsigned target;
        int unsigned r;
        int unsigned k;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_PUSH;
        m_axis_tready = 1'b0;

        // directed: every reader on an empty stack, reserved codes, extremes,
        // ties in pop max including all-most-negative
        queue_cmd(CMD_POP,      $urandom());
        queue_cmd(CMD_TOP,      $urandom());
        queue_cmd(CMD_PEEK_MAX, $urandom());
        queue_cmd(CMD_POP_MAX,  $urandom());
        queue_cmd(CMD_RSVD_A,   $urandom());
        queue_cmd(CMD_RSVD_B,   $urandom());
        queue_cmd(CMD_RSVD_C,   $urandom());
        queue_cmd(CMD_PUSH,     MOST_NEG);
        queue_cmd(CMD_PUSH,     '1);
        queue_cmd(CMD_PUSH,     MOST_POS);
        queue_cmd(CMD_PUSH,     '0);
        queue_cmd(CMD_PUSH,     MOST_NEG);
        queue_cmd(CMD_TOP,      '0);
        queue_cmd(CMD_PEEK_MAX, '1);
        queue_cmd(CMD_POP_MAX,  '0);       // takes the most positive word from mid-stack
        queue_cmd(CMD_POP_MAX,  '0);       // zero
        queue_cmd(CMD_POP,      '0);       // most negative off the top
        queue_cmd(CMD_POP_MAX,  '0);       // -1
        queue_cmd(CMD_PUSH,     MOST_NEG);
        queue_cmd(CMD_PUSH,     MOST_NEG);
        queue_cmd(CMD_POP_MAX,  '0);       // three equal most-negative words
        queue_cmd(CMD_PEEK_MAX, '0);
        queue_cmd(CMD_POP_MAX,  '0);
        queue_cmd(CMD_POP_MAX,  '0);
        queue_cmd(CMD_RSVD_C,   '1);

        // random: mostly stack-shaped runs heading for a random depth, with
        // runs to full and beyond, drains to empty and reserved-code noise
        k = cmd_backlog.size();
        while (cmd_backlog.size() < k + RANDOM_WORDS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                run_len = $urandom_range(10, 40);
                target  = $urandom_range(0, DEPTH);
                repeat (run_len)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        queue_cmd(pick_reserved(), $urandom());
                    else if (r < (gen_depth < target ? 65 : 30))
                        queue_cmd(CMD_PUSH, pick_value());
                    else
                        queue_cmd(pick_reader(), $urandom());
                end
            end
            else if (kind < 85)
            begin
                while (gen_depth < DEPTH)
                    queue_cmd(CMD_PUSH, pick_value());
                repeat ($urandom_range(1, 3))
                    queue_cmd(CMD_PUSH, pick_value());     // dropped: stack full
                repeat ($urandom_range(1, 4))
                    queue_cmd(CMD_POP_MAX, $urandom());
            end
            else if (kind < 95)
            begin
                while (gen_depth > 0)
                    queue_cmd($urandom_range(0, 1) ? CMD_POP : CMD_POP_MAX, $urandom());
                repeat ($urandom_range(1, 3))
                    queue_cmd(pick_reader(), $urandom());  // all on an empty stack
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    queue_cmd(pick_reserved(), $urandom());
            end
        end
        stim_total = cmd_backlog.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_taken < stim_total)
            @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
        // any further word from here on has no prediction and is flagged
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("max_stack_engine regression: pass");
        else
            $display("max_stack_engine regression: fail");
        $finish;
    end

endmodule
